// File: hw/rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants of the vertex normal accumulator
// Holds the opcode codes, the command word passed from the front part to the
// back part, and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int IDX_W    = 12;
  localparam int NORM_W   = 16;
  localparam int SUM_W    = 24;
  localparam int OPCODE_W = 2;
  localparam int VCOUNT_W = 13;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;

  localparam logic [SUM_W-1:0] SUM_MAX = 24'h7F_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 24'h80_0000;

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_ACC      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLR = 2'd2;

  // Command queue depth (a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    CMD_ACC,
    CMD_READ,
    CMD_READ_CLR,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_W-1:0]          idx_a;
    logic [IDX_W-1:0]          idx_b;
    logic [IDX_W-1:0]          idx_c;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC1,
    ST_ACC2,
    ST_ACC3,
    ST_READ
  } back_state_t;

endpackage

// File: hw/rtl/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front: input acceptance and classification
// Holds the vertex count register, checks the indices of each input word and
// turns it into a command for the queue.
// ----------------------------------------------------------------------------
module vna_front #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [vna_pkg::VCOUNT_W-1:0]         cfg_write_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vna_pkg::OPCODE_W-1:0]         opcode,
  input  logic [vna_pkg::IDX_W-1:0]            vertex_a,
  input  logic [vna_pkg::IDX_W-1:0]            vertex_b,
  input  logic [vna_pkg::IDX_W-1:0]            vertex_c,
  input  logic signed [vna_pkg::NORM_W-1:0]    face_nx,
  input  logic signed [vna_pkg::NORM_W-1:0]    face_ny,
  input  logic signed [vna_pkg::NORM_W-1:0]    face_nz,
  input  logic                                 clearing,
  input  logic                                 queue_full,
  output logic                                 push,
  output vna_pkg::cmd_t                        push_cmd
);

  logic [vna_pkg::VCOUNT_W-1:0] vertex_count;
  logic ok_a;
  logic ok_b;
  logic ok_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= vna_pkg::VCOUNT_RESET;
    end else if (cfg_write_en) begin
      vertex_count <= cfg_write_data;
    end
  end

  function automatic logic idx_ok(logic [vna_pkg::IDX_W-1:0] idx,
                                  logic [vna_pkg::VCOUNT_W-1:0] count);
    return ({1'b0, idx} < count) && (32'(idx) < 32'(MAX_VERTICES));
  endfunction

  assign ok_a = idx_ok(vertex_a, vertex_count);
  assign ok_b = idx_ok(vertex_b, vertex_count);
  assign ok_c = idx_ok(vertex_c, vertex_count);

  assign in_ready = !clearing && !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.idx_a = vertex_a;
    push_cmd.idx_b = vertex_b;
    push_cmd.idx_c = vertex_c;
    push_cmd.nx    = face_nx;
    push_cmd.ny    = face_ny;
    push_cmd.nz    = face_nz;
    unique case (opcode)
      vna_pkg::OP_ACC: begin
        push_cmd.kind = (ok_a && ok_b && ok_c) ? vna_pkg::CMD_ACC : vna_pkg::CMD_DROP;
      end
      vna_pkg::OP_READ: begin
        push_cmd.kind = ok_a ? vna_pkg::CMD_READ : vna_pkg::CMD_DROP;
      end
      vna_pkg::OP_READ_CLR: begin
        push_cmd.kind = ok_a ? vna_pkg::CMD_READ_CLR : vna_pkg::CMD_DROP;
      end
      default: begin
        push_cmd.kind = vna_pkg::CMD_DROP;
      end
    endcase
  end

endmodule

// File: hw/rtl/vna_queue.sv
// ----------------------------------------------------------------------------
// vna_queue: command queue
// A short first-in first-out buffer of commands between the front part and
// the back part.
// ----------------------------------------------------------------------------
module vna_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vna_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output vna_pkg::cmd_t head
);

  vna_pkg::cmd_t                entries [vna_pkg::QUEUE_DEPTH];
  logic [vna_pkg::QPTR_W-1:0]   wptr;
  logic [vna_pkg::QPTR_W-1:0]   rptr;
  logic [vna_pkg::QPTR_W:0]     count;

  assign full      = (count == (vna_pkg::QPTR_W+1)'(vna_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back: vertex store sequencer
// Owns the vertex sum memory, clears it after reset, runs the
// read-modify-write steps of each command and holds the result register.
// ----------------------------------------------------------------------------
module vna_back #(
  parameter int MAX_VERTICES = 4096,
  parameter int ACC_WIDTH    = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              clearing,
  input  logic                              cmd_valid,
  input  vna_pkg::cmd_t                     cmd_head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic                              saturated,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_x,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_y,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_z
);

  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IW     = (AW > vna_pkg::IDX_W) ? AW : vna_pkg::IDX_W;
  localparam int DW     = 3 * ACC_WIDTH;
  localparam int AW1    = ACC_WIDTH + 1;
  localparam int OW     = (ACC_WIDTH > vna_pkg::SUM_W) ? ACC_WIDTH : vna_pkg::SUM_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  logic [DW-1:0] mem [MAX_VERTICES];

  vna_pkg::back_state_t state;
  vna_pkg::back_state_t state_next;
  vna_pkg::cmd_t        cur;

  logic [AW-1:0] clr_addr;
  logic          sat_acc;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_q;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en_q;
  logic [AW-1:0] wr_addr_q;
  logic [DW-1:0] wr_data_q;

  logic [DW-1:0]        old_word;
  logic [AW1-1:0]       add_x;
  logic [AW1-1:0]       add_y;
  logic [AW1-1:0]       add_z;
  logic                 clip;
  logic                 out_free;
  logic                 out_load;
  logic                 out_status_next;
  logic                 out_sat_next;
  logic [vna_pkg::SUM_W-1:0] out_x_next;
  logic [vna_pkg::SUM_W-1:0] out_y_next;
  logic [vna_pkg::SUM_W-1:0] out_z_next;

  function automatic logic [AW-1:0] to_addr(logic [vna_pkg::IDX_W-1:0] idx);
    logic [IW-1:0] wide;
    wide = IW'(idx);
    return wide[AW-1:0];
  endfunction

  // Returns {clipped, saturated sum}.
  function automatic logic [AW1-1:0] sat_add(logic [ACC_WIDTH-1:0] acc,
                                             logic [vna_pkg::NORM_W-1:0] n);
    logic [AW1-1:0] s;
    logic [ACC_WIDTH-1:0] v;
    logic ovf;
    s   = AW1'($signed(acc)) + AW1'($signed(n));
    ovf = s[ACC_WIDTH] != s[ACC_WIDTH-1];
    if (!ovf) begin
      v = s[ACC_WIDTH-1:0];
    end else if (s[ACC_WIDTH]) begin
      v = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      v = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
    return {ovf, v};
  endfunction

  function automatic logic [vna_pkg::SUM_W-1:0] to_out(logic [ACC_WIDTH-1:0] acc);
    logic [OW-1:0] e;
    logic [OW-vna_pkg::SUM_W:0] top;
    e   = OW'($signed(acc));
    top = e[OW-1:vna_pkg::SUM_W-1];
    if ((&top) || !(|top)) begin
      return e[vna_pkg::SUM_W-1:0];
    end else if (e[OW-1]) begin
      return vna_pkg::SUM_MIN;
    end else begin
      return vna_pkg::SUM_MAX;
    end
  endfunction

  // A write in the cycle of the read is not yet seen by the memory output.
  assign old_word = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : rd_data;

  assign add_x = sat_add(old_word[DW-1:2*ACC_WIDTH], cur.nx);
  assign add_y = sat_add(old_word[2*ACC_WIDTH-1:ACC_WIDTH], cur.ny);
  assign add_z = sat_add(old_word[ACC_WIDTH-1:0], cur.nz);
  assign clip  = add_x[ACC_WIDTH] | add_y[ACC_WIDTH] | add_z[ACC_WIDTH];

  assign out_free = !out_valid || out_ready;
  assign clearing = (state == vna_pkg::ST_CLEAR);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vna_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = vna_pkg::ST_IDLE;
        end
      end
      vna_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          unique case (cmd_head.kind) inside
            vna_pkg::CMD_ACC:                         state_next = vna_pkg::ST_ACC1;
            vna_pkg::CMD_READ, vna_pkg::CMD_READ_CLR: state_next = vna_pkg::ST_READ;
            default:                                  state_next = vna_pkg::ST_IDLE;
          endcase
        end
      end
      vna_pkg::ST_ACC1: state_next = vna_pkg::ST_ACC2;
      vna_pkg::ST_ACC2: state_next = vna_pkg::ST_ACC3;
      vna_pkg::ST_ACC3: state_next = vna_pkg::ST_IDLE;
      vna_pkg::ST_READ: state_next = vna_pkg::ST_IDLE;
      default:          state_next = vna_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = to_addr(cur.idx_b);
    wr_en           = 1'b0;
    wr_addr         = to_addr(cur.idx_a);
    wr_data         = {add_x[ACC_WIDTH-1:0], add_y[ACC_WIDTH-1:0], add_z[ACC_WIDTH-1:0]};
    out_load        = 1'b0;
    out_status_next = 1'b0;
    out_sat_next    = 1'b0;
    out_x_next      = '0;
    out_y_next      = '0;
    out_z_next      = '0;
    unique case (state)
      vna_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      vna_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          pop     = 1'b1;
          rd_addr = to_addr(cmd_head.idx_a);
          if (cmd_head.kind == vna_pkg::CMD_DROP) begin
            out_load        = 1'b1;
            out_status_next = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      vna_pkg::ST_ACC1: begin
        wr_en   = 1'b1;
        wr_addr = to_addr(cur.idx_a);
        rd_en   = 1'b1;
        rd_addr = to_addr(cur.idx_b);
      end
      vna_pkg::ST_ACC2: begin
        wr_en   = 1'b1;
        wr_addr = to_addr(cur.idx_b);
        rd_en   = 1'b1;
        rd_addr = to_addr(cur.idx_c);
      end
      vna_pkg::ST_ACC3: begin
        wr_en        = 1'b1;
        wr_addr      = to_addr(cur.idx_c);
        out_load     = 1'b1;
        out_sat_next = sat_acc | clip;
      end
      vna_pkg::ST_READ: begin
        out_load   = 1'b1;
        out_x_next = to_out(old_word[DW-1:2*ACC_WIDTH]);
        out_y_next = to_out(old_word[2*ACC_WIDTH-1:ACC_WIDTH]);
        out_z_next = to_out(old_word[ACC_WIDTH-1:0]);
        if (cur.kind == vna_pkg::CMD_READ_CLR) begin
          wr_en   = 1'b1;
          wr_addr = to_addr(cur.idx_a);
          wr_data = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vna_pkg::ST_CLEAR;
      clr_addr  <= '0;
      wr_en_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_en_q <= wr_en;
      if (state == vna_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_q <= wr_addr;
    wr_data_q <= wr_data;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (pop) begin
      cur <= cmd_head;
    end
    if (state == vna_pkg::ST_ACC1) begin
      sat_acc <= clip;
    end else if (state == vna_pkg::ST_ACC2) begin
      sat_acc <= sat_acc | clip;
    end
    if (out_load) begin
      status    <= out_status_next;
      saturated <= out_sat_next;
      sum_x     <= out_x_next;
      sum_y     <= out_y_next;
      sum_z     <= out_z_next;
    end
  end

endmodule

// File: hw/rtl/vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top: per-vertex normal sum accumulator
// Adds face normals into a table of vertex sums and reads sums back, with an
// optional clear of the entry that is read.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-----------------------------------------
//   input    | in_valid / in_ready     | opcode, vertex_a/b/c, face_nx/ny/nz
//   output   | out_valid / out_ready   | status, saturated, sum_x/y/z
//   config   | cfg_write_en            | cfg_write_data (vertex count)
//
// After reset the vertex memory is cleared one entry a cycle; in_ready stays
// low until the pass ends. Config writes are taken at any time.
// In the back part an accumulate word runs three overlapped read-modify-write
// updates on the vertex memory (one read and one write port) in ST_ACC1 to
// ST_ACC3, a read answers in ST_READ and a dropped word straight from ST_IDLE.
// A two-entry command queue lets input words be taken while a result word
// waits on out_ready; the sequencer starts a command only when the result
// register is free, so it never stalls mid-update.
//
// The front part checks every index against the vertex count and against
// MAX_VERTICES. A face with any bad index, a read of a bad index and the
// unused opcode all return status 1 and change nothing. Accumulators are
// ACC_WIDTH bits wide with 14 fraction bits, and every addition saturates;
// reads report the sum saturated to the 24-bit output range.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = 4096,
  parameter int ACC_WIDTH    = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [vna_pkg::VCOUNT_W-1:0]      cfg_write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vna_pkg::OPCODE_W-1:0]      opcode,
  input  logic [vna_pkg::IDX_W-1:0]         vertex_a,
  input  logic [vna_pkg::IDX_W-1:0]         vertex_b,
  input  logic [vna_pkg::IDX_W-1:0]         vertex_c,
  input  logic signed [vna_pkg::NORM_W-1:0] face_nx,
  input  logic signed [vna_pkg::NORM_W-1:0] face_ny,
  input  logic signed [vna_pkg::NORM_W-1:0] face_nz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic                              saturated,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_x,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_y,
  output logic signed [vna_pkg::SUM_W-1:0]  sum_z
);

  // Command path from the front part through the queue to the back part.
  logic          clearing;
  logic          queue_full;
  logic          push;
  vna_pkg::cmd_t push_cmd;
  logic          pop;
  logic          cmd_valid;
  vna_pkg::cmd_t cmd_head;

  vna_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .vertex_c       (vertex_c),
    .face_nx        (face_nx),
    .face_ny        (face_ny),
    .face_nz        (face_nz),
    .clearing       (clearing),
    .queue_full     (queue_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  vna_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  vna_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .saturated (saturated),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .sum_z     (sum_z)
  );

endmodule
